/* design/cse_pkg.sv */
package cse_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_N       = 24;

	// Widths of the datapath.
	localparam int VW  = 48;              // output vector component
	localparam int SW  = VW + 2;          // sum of up to three components
	localparam int PW  = 96;              // product handed to rounding
	localparam int CW  = 34;              // CORDIC x, y and angle accumulator
	localparam int TW  = FRAC_BITS + 3;   // rounded cos and sin
	localparam int AXW = 18;              // frame axis component

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 54;

	localparam logic signed [CW-1:0] CORDIC_K = CW'(652032874);
	localparam logic signed [CW-1:0] TRIG_RND = CW'(1) << (29 - FRAC_BITS);
	localparam int TRIG_SH = 30 - FRAC_BITS;

	localparam logic signed [SW-1:0] ONE = SW'(1) << FRAC_BITS;

	localparam logic signed [VW-1:0] SAT_MAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] SAT_MIN = {1'b1, {(VW-1){1'b0}}};
	localparam logic signed [PW-1:0] SAT_MAX_P = PW'({1'b0, {(VW-1){1'b1}}});
	localparam logic signed [PW-1:0] SAT_MIN_P = ~SAT_MAX_P;
	localparam logic signed [SW-1:0] SAT_MAX_W = SW'({1'b0, {(VW-1){1'b1}}});
	localparam logic signed [SW-1:0] SAT_MIN_W = ~SAT_MAX_W;
	localparam logic signed [PW-1:0] RND_POS = PW'(1) << (FRAC_BITS - 1);
	localparam logic signed [PW-1:0] RND_NEG = RND_POS - PW'(1);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_X   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_Y   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_Z   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_TRIG = 3'd7;

	localparam logic [53:0] FRAME_X_RST = 54'd65536;
	localparam logic [53:0] FRAME_Y_RST = 54'd17179869184;
	localparam logic [53:0] FRAME_Z_RST = 54'd4503599627370496;
	localparam logic [31:0] RADIUS_RST  = 32'd65536;
	localparam logic [33:0] TRIG_RST    = 34'd6074053893;

	// Result kinds, in emission order.
	localparam logic [2:0] KIND_POS = 3'd0;
	localparam logic [2:0] KIND_DU  = 3'd1;
	localparam logic [2:0] KIND_DV  = 3'd2;
	localparam logic [2:0] KIND_NRM = 3'd3;
	localparam logic [2:0] KIND_DUU = 3'd4;
	localparam logic [2:0] KIND_DUV = 3'd5;
	localparam int NUM_KINDS = 6;

	typedef struct packed {
		logic [15:0]        u_angle;
		logic signed [31:0] v_param;
		logic [5:0]         want_mask;
	} item_t;

	typedef struct packed {
		logic [2:0]           quantity_kind;
		logic signed [VW-1:0] vec_x;
		logic signed [VW-1:0] vec_y;
		logic signed [VW-1:0] vec_z;
		logic                 last_of_run;
	} result_t;

	// Arctangent of 2^-i in units of 2^-32 turn.
	function automatic logic signed [CW-1:0] atan_turn(input int i);
		case (i)
			0: atan_turn = CW'(536870912);
			1: atan_turn = CW'(316933406);
			2: atan_turn = CW'(167458907);
			3: atan_turn = CW'(85004756);
			4: atan_turn = CW'(42667331);
			5: atan_turn = CW'(21354465);
			6: atan_turn = CW'(10680862);
			7: atan_turn = CW'(5340245);
			8: atan_turn = CW'(2670163);
			9: atan_turn = CW'(1335087);
			10: atan_turn = CW'(667544);
			11: atan_turn = CW'(333772);
			12: atan_turn = CW'(166886);
			13: atan_turn = CW'(83443);
			14: atan_turn = CW'(41722);
			15: atan_turn = CW'(20861);
			16: atan_turn = CW'(10430);
			17: atan_turn = CW'(5215);
			18: atan_turn = CW'(2608);
			19: atan_turn = CW'(1304);
			20: atan_turn = CW'(652);
			21: atan_turn = CW'(326);
			22: atan_turn = CW'(163);
			23: atan_turn = CW'(81);
			default: atan_turn = '0;
		endcase
	endfunction

	// Drops the fraction bits of a full product, rounding half away from zero,
	// and saturates to the output range.
	function automatic logic signed [VW-1:0] round_sat(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] t;
		logic signed [PW-1:0] q;
		t = p + (p[PW-1] ? RND_NEG : RND_POS);
		q = t >>> FRAC_BITS;
		if (q > SAT_MAX_P)
			round_sat = SAT_MAX;
		else if (q < SAT_MIN_P)
			round_sat = SAT_MIN;
		else
			round_sat = q[VW-1:0];
	endfunction

	function automatic logic signed [VW-1:0] sat_sum(input logic signed [SW-1:0] s);
		if (s > SAT_MAX_W)
			sat_sum = SAT_MAX;
		else if (s < SAT_MIN_W)
			sat_sum = SAT_MIN;
		else
			sat_sum = s[VW-1:0];
	endfunction

endpackage

/* design/cse_cordic.sv */
module cse_cordic #(
	parameter int STEPS  = cse_pkg::CORDIC_STEPS,
	parameter int SIDE_W = 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic signed [cse_pkg::CW-1:0]  in_x,
	input  logic signed [cse_pkg::CW-1:0]  in_y,
	input  logic signed [cse_pkg::CW-1:0]  in_z,
	input  logic [SIDE_W-1:0]              in_side,
	output logic                           out_valid,
	output logic signed [cse_pkg::CW-1:0]  out_x,
	output logic signed [cse_pkg::CW-1:0]  out_y,
	output logic [SIDE_W-1:0]              out_side
);

	logic signed [cse_pkg::CW-1:0] x_c [STEPS+1];
	logic signed [cse_pkg::CW-1:0] y_c [STEPS+1];
	logic signed [cse_pkg::CW-1:0] z_c [STEPS+1];
	logic [SIDE_W-1:0]             side_c [STEPS+1];
	logic                          val_c [STEPS+1];

	logic signed [cse_pkg::CW-1:0] x_s [STEPS];
	logic signed [cse_pkg::CW-1:0] y_s [STEPS];
	logic signed [cse_pkg::CW-1:0] z_s [STEPS];
	logic [SIDE_W-1:0]             side_s [STEPS];
	logic                          val_s [STEPS];

	assign x_c[0]    = in_x;
	assign y_c[0]    = in_y;
	assign z_c[0]    = in_z;
	assign side_c[0] = in_side;
	assign val_c[0]  = in_valid;

	// One rotation step per stage; the shifts are arithmetic, so they floor.
	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [cse_pkg::CW-1:0] dx;
		logic signed [cse_pkg::CW-1:0] dy;

		assign dx = y_c[i] >>> i;
		assign dy = x_c[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				val_s[i] <= 1'b0;
			else
				val_s[i] <= val_c[i];
		end

		always_ff @(posedge clk) begin
			if (!z_c[i][cse_pkg::CW-1]) begin
				x_s[i] <= x_c[i] - dx;
				y_s[i] <= y_c[i] + dy;
				z_s[i] <= z_c[i] - cse_pkg::atan_turn(i);
			end else begin
				x_s[i] <= x_c[i] + dx;
				y_s[i] <= y_c[i] - dy;
				z_s[i] <= z_c[i] + cse_pkg::atan_turn(i);
			end
			side_s[i] <= side_c[i];
		end

		assign x_c[i+1]    = x_s[i];
		assign y_c[i+1]    = y_s[i];
		assign z_c[i+1]    = z_s[i];
		assign side_c[i+1] = side_s[i];
		assign val_c[i+1]  = val_s[i];
	end

	assign out_valid = val_c[STEPS];
	assign out_x     = x_c[STEPS];
	assign out_y     = y_c[STEPS];
	assign out_side  = side_c[STEPS];

endmodule

/* design/cone_surface_evaluate_unit.sv */
// Requests are paced: busy holds off a new request while the vectors of the last one
// still need output slots, since the single result port gives one vector per cycle and
// the receiver cannot stall. The pipeline itself (a capture stage, the CORDIC stages,
// then six arithmetic stages) never stalls.
// Reset clears all valid bits, the pending-result mask and the configuration registers
// to their defaults; no clearing pass is needed.
module cone_surface_evaluate_unit #(
	parameter int CORDIC_STEPS = cse_pkg::CORDIC_STEPS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  cse_pkg::item_t                      item,
	output cse_pkg::result_t                    result,
	output logic                                strobe,
	input  logic                                cfg_we,
	input  logic [cse_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cse_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int VW     = cse_pkg::VW;
	localparam int SW     = cse_pkg::SW;
	localparam int PW     = cse_pkg::PW;
	localparam int CW     = cse_pkg::CW;
	localparam int TW     = cse_pkg::TW;
	localparam int AXW    = cse_pkg::AXW;
	localparam int RW     = 21;   // radial and tangent components stay below 2^20
	localparam int HALF   = VW / 2;
	localparam int SIDE_W = 32 + 6 + 2;

	localparam int P_AC  = AXW + TW;
	localparam int P_VSH = 32 + 18;
	localparam int P_VR  = 32 + 33;
	localparam int P_RT  = 33 + 18;
	localparam int P_RWH = 33 + HALF;
	localparam int P_RWL = 33 + HALF + 1;
	localparam int P_ZS  = VW + 18;
	localparam int P_NR  = RW + 18;
	localparam int P_NZ  = AXW + 18;
	localparam int P_RV  = RW + VW;
	localparam int P_AV  = AXW + VW;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [16:0] EIGHTH_TURN = 17'd8192;
	localparam logic signed [14:0] RESID_BIAS = 15'sd8192;

	// Configuration registers.
	logic signed [31:0] origin_x_q, origin_y_q, origin_z_q;
	logic [53:0]        frame_x_q, frame_y_q, frame_z_q;
	logic [31:0]        radius_q;
	logic [33:0]        trig_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			origin_z_q <= '0;
			frame_x_q  <= cse_pkg::FRAME_X_RST;
			frame_y_q  <= cse_pkg::FRAME_Y_RST;
			frame_z_q  <= cse_pkg::FRAME_Z_RST;
			radius_q   <= cse_pkg::RADIUS_RST;
			trig_q     <= cse_pkg::TRIG_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				cse_pkg::REG_ORIGIN_X:  origin_x_q <= cfg_data[31:0];
				cse_pkg::REG_ORIGIN_Y:  origin_y_q <= cfg_data[31:0];
				cse_pkg::REG_ORIGIN_Z:  origin_z_q <= cfg_data[31:0];
				cse_pkg::REG_FRAME_X:   frame_x_q  <= cfg_data[53:0];
				cse_pkg::REG_FRAME_Y:   frame_y_q  <= cfg_data[53:0];
				cse_pkg::REG_FRAME_Z:   frame_z_q  <= cfg_data[53:0];
				cse_pkg::REG_RADIUS:    radius_q   <= cfg_data[31:0];
				cse_pkg::REG_HALF_TRIG: trig_q     <= cfg_data[33:0];
				default: ;
			endcase
		end
	end

	logic signed [AXW-1:0] ax [3];
	logic signed [AXW-1:0] ay [3];
	logic signed [AXW-1:0] az [3];
	logic signed [31:0]    org [3];
	logic signed [17:0]    cos_h, sin_h;
	logic signed [32:0]    rad_r;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ax[k] = frame_x_q[AXW*k +: AXW];
			ay[k] = frame_y_q[AXW*k +: AXW];
			az[k] = frame_z_q[AXW*k +: AXW];
		end
		org[0] = origin_x_q;
		org[1] = origin_y_q;
		org[2] = origin_z_q;
	end

	assign cos_h = {1'b0, trig_q[16:0]};
	assign sin_h = {1'b0, trig_q[33:17]};
	assign rad_r = {1'b0, radius_q};

	// Request pacing: one result slot per cycle on the output.
	logic       accept;
	logic [2:0] gap_q;
	logic [2:0] nres;

	assign accept = start & ~busy;
	assign busy   = (gap_q != 3'd0);

	always_comb begin
		nres = 3'd0;
		for (int i = 0; i < cse_pkg::NUM_KINDS; i++)
			nres = nres + 3'(item.want_mask[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			gap_q <= 3'd0;
		else if (accept)
			gap_q <= (nres == 3'd0) ? 3'd0 : nres - 3'd1;
		else if (gap_q != 3'd0)
			gap_q <= gap_q - 3'd1;
	end

	// Stage 1: capture the request and split the angle into quadrant and residual.
	logic           valid_s1;
	cse_pkg::item_t item_s1;
	logic [16:0]    ang_sum;
	logic [1:0]     quad;
	logic signed [14:0]    resid;
	logic signed [CW-1:0]  z0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= item;
	end

	assign ang_sum = {1'b0, item_s1.u_angle} + EIGHTH_TURN;
	assign quad    = ang_sum[15:14];
	assign resid   = $signed({1'b0, ang_sum[13:0]}) - RESID_BIAS;
	assign z0      = {{(CW-31){resid[14]}}, resid, 16'b0};

	logic                 cord_valid;
	logic signed [CW-1:0] cord_x, cord_y;
	logic [SIDE_W-1:0]    cord_side;

	cse_cordic #(
		.STEPS  (CORDIC_STEPS),
		.SIDE_W (SIDE_W)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_x      (cse_pkg::CORDIC_K),
		.in_y      ('0),
		.in_z      (z0),
		.in_side   ({item_s1.v_param, item_s1.want_mask, quad}),
		.out_valid (cord_valid),
		.out_x     (cord_x),
		.out_y     (cord_y),
		.out_side  (cord_side)
	);

	// Stage 2: round cos/sin, apply the quadrant, first scale products.
	logic signed [31:0]   v_c;
	logic [5:0]           mask_c;
	logic [1:0]           quad_c;
	logic signed [CW-1:0] xr_sh, yr_sh;
	logic signed [TW-1:0] cr, sr, cq, sq;

	assign v_c    = cord_side[39:8];
	assign mask_c = cord_side[7:2];
	assign quad_c = cord_side[1:0];
	assign xr_sh  = (cord_x + cse_pkg::TRIG_RND) >>> cse_pkg::TRIG_SH;
	assign yr_sh  = (cord_y + cse_pkg::TRIG_RND) >>> cse_pkg::TRIG_SH;
	assign cr     = xr_sh[TW-1:0];
	assign sr     = yr_sh[TW-1:0];

	always_comb begin
		case (quad_c)
			QUAD_0: begin
				cq = cr;
				sq = sr;
			end
			QUAD_1: begin
				cq = -sr;
				sq = cr;
			end
			QUAD_2: begin
				cq = -cr;
				sq = -sr;
			end
			default: begin
				cq = sr;
				sq = -cr;
			end
		endcase
	end

	logic                  valid_s2;
	logic [5:0]            mask_s2;
	logic signed [TW-1:0]  c_s2, s_s2;
	logic signed [P_VSH-1:0] p_vsh_s2;
	logic signed [P_VR-1:0]  p_vr_s2;
	logic signed [P_RT-1:0]  p_rsh_s2, p_rch_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else
			valid_s2 <= cord_valid;
	end

	always_ff @(posedge clk) begin
		mask_s2  <= mask_c;
		c_s2     <= cq;
		s_s2     <= sq;
		p_vsh_s2 <= v_c * sin_h;
		p_vr_s2  <= v_c * rad_r;
		p_rsh_s2 <= rad_r * sin_h;
		p_rch_s2 <= rad_r * cos_h;
	end

	// Stage 3: frame-by-trig products; finish the scales that need one product.
	logic                   valid_s3;
	logic [5:0]             mask_s3;
	logic signed [P_AC-1:0] axc_s3 [3];
	logic signed [P_AC-1:0] ays_s3 [3];
	logic signed [P_AC-1:0] ayc_s3 [3];
	logic signed [P_AC-1:0] axs_s3 [3];
	logic signed [VW-1:0]   w_s3, m2_s3, dvs_s3, dzs_s3;
	logic signed [VW-1:0]   m1_c, rsh_c;

	assign m1_c  = cse_pkg::round_sat(PW'(p_vsh_s2));
	assign rsh_c = cse_pkg::round_sat(PW'(p_rsh_s2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else
			valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		mask_s3 <= mask_s2;
		for (int k = 0; k < 3; k++) begin
			axc_s3[k] <= ax[k] * c_s2;
			ays_s3[k] <= ay[k] * s_s2;
			ayc_s3[k] <= ay[k] * c_s2;
			axs_s3[k] <= ax[k] * s_s2;
		end
		w_s3   <= cse_pkg::sat_sum(cse_pkg::ONE - SW'(m1_c));
		m2_s3  <= cse_pkg::round_sat(PW'(p_vr_s2));
		dvs_s3 <= cse_pkg::sat_sum(SW'(0) - SW'(rsh_c));
		dzs_s3 <= cse_pkg::round_sat(PW'(p_rch_s2));
	end

	// Stage 4: radial and tangent directions; radius times the v scale, split in halves.
	logic                    valid_s4;
	logic [5:0]              mask_s4;
	logic signed [RW-1:0]    rad_s4 [3];
	logic signed [RW-1:0]    tan_s4 [3];
	logic signed [VW-1:0]    rad_f [3];
	logic signed [VW-1:0]    tan_f [3];
	logic signed [P_RWH-1:0] p_rwh_s4;
	logic signed [P_RWL-1:0] p_rwl_s4;
	logic signed [P_ZS-1:0]  p_zs_s4;
	logic signed [VW-1:0]    dvs_s4, dzs_s4;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rad_f[k] = cse_pkg::sat_sum(SW'(cse_pkg::round_sat(PW'(axc_s3[k])))
				+ SW'(cse_pkg::round_sat(PW'(ays_s3[k]))));
			tan_f[k] = cse_pkg::sat_sum(SW'(cse_pkg::round_sat(PW'(ayc_s3[k])))
				- SW'(cse_pkg::round_sat(PW'(axs_s3[k]))));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s4 <= 1'b0;
		else
			valid_s4 <= valid_s3;
	end

	always_ff @(posedge clk) begin
		mask_s4 <= mask_s3;
		for (int k = 0; k < 3; k++) begin
			rad_s4[k] <= rad_f[k][RW-1:0];
			tan_s4[k] <= tan_f[k][RW-1:0];
		end
		p_rwh_s4 <= rad_r * $signed(w_s3[VW-1:HALF]);
		p_rwl_s4 <= rad_r * $signed({1'b0, w_s3[HALF-1:0]});
		p_zs_s4  <= m2_s3 * cos_h;
		dvs_s4   <= dvs_s3;
		dzs_s4   <= dzs_s3;
	end

	// Stage 5: finish vscale and zscale; products for dv, normal and duv.
	logic                   valid_s5;
	logic [5:0]             mask_s5;
	logic signed [RW-1:0]   rad_s5 [3];
	logic signed [RW-1:0]   tan_s5 [3];
	logic signed [VW-1:0]   vscale_s5, zscale_s5;
	logic signed [P_NR-1:0] p_nr_s5 [3];
	logic signed [P_NZ-1:0] p_nz_s5 [3];
	logic signed [P_RV-1:0] p_dr_s5 [3];
	logic signed [P_AV-1:0] p_dz_s5 [3];
	logic signed [P_RV-1:0] p_tdv_s5 [3];
	logic signed [PW-1:0]   rw_full;

	assign rw_full = (PW'(p_rwh_s4) <<< HALF) + PW'(p_rwl_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s5 <= 1'b0;
		else
			valid_s5 <= valid_s4;
	end

	always_ff @(posedge clk) begin
		mask_s5   <= mask_s4;
		vscale_s5 <= cse_pkg::round_sat(rw_full);
		zscale_s5 <= cse_pkg::round_sat(PW'(p_zs_s4));
		for (int k = 0; k < 3; k++) begin
			rad_s5[k]   <= rad_s4[k];
			tan_s5[k]   <= tan_s4[k];
			p_nr_s5[k]  <= rad_s4[k] * cos_h;
			p_nz_s5[k]  <= az[k] * sin_h;
			p_dr_s5[k]  <= rad_s4[k] * dvs_s4;
			p_dz_s5[k]  <= az[k] * dzs_s4;
			p_tdv_s5[k] <= tan_s4[k] * dvs_s4;
		end
	end

	// Stage 6: finish dv, normal and duv; products with vscale and zscale.
	logic                   valid_s6;
	logic [5:0]             mask_s6;
	logic signed [VW-1:0]   dv_s6 [3];
	logic signed [VW-1:0]   nrm_s6 [3];
	logic signed [VW-1:0]   duv_s6 [3];
	logic signed [P_RV-1:0] p_rv_s6 [3];
	logic signed [P_AV-1:0] p_zz_s6 [3];
	logic signed [P_RV-1:0] p_tv_s6 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s6 <= 1'b0;
		else
			valid_s6 <= valid_s5;
	end

	always_ff @(posedge clk) begin
		mask_s6 <= mask_s5;
		for (int k = 0; k < 3; k++) begin
			dv_s6[k]  <= cse_pkg::sat_sum(SW'(cse_pkg::round_sat(PW'(p_dr_s5[k])))
				+ SW'(cse_pkg::round_sat(PW'(p_dz_s5[k]))));
			nrm_s6[k] <= cse_pkg::sat_sum(SW'(cse_pkg::round_sat(PW'(p_nr_s5[k])))
				+ SW'(cse_pkg::round_sat(PW'(p_nz_s5[k]))));
			duv_s6[k] <= cse_pkg::round_sat(PW'(p_tdv_s5[k]));
			p_rv_s6[k] <= rad_s5[k] * vscale_s5;
			p_zz_s6[k] <= az[k] * zscale_s5;
			p_tv_s6[k] <= tan_s5[k] * vscale_s5;
		end
	end

	// Stage 7: all six vectors. They are held here until the next request arrives,
	// which the pacing guarantees happens no earlier than the last of them is sent.
	logic signed [VW-1:0] vec_s7 [cse_pkg::NUM_KINDS][3];
	logic signed [VW-1:0] rv_c [3];

	always_comb begin
		for (int k = 0; k < 3; k++)
			rv_c[k] = cse_pkg::round_sat(PW'(p_rv_s6[k]));
	end

	always_ff @(posedge clk) begin
		if (valid_s6) begin
			for (int k = 0; k < 3; k++) begin
				vec_s7[cse_pkg::KIND_POS][k] <= cse_pkg::sat_sum(SW'(org[k]) + SW'(rv_c[k])
					+ SW'(cse_pkg::round_sat(PW'(p_zz_s6[k]))));
				vec_s7[cse_pkg::KIND_DU][k]  <= cse_pkg::round_sat(PW'(p_tv_s6[k]));
				vec_s7[cse_pkg::KIND_DV][k]  <= dv_s6[k];
				vec_s7[cse_pkg::KIND_NRM][k] <= nrm_s6[k];
				vec_s7[cse_pkg::KIND_DUU][k] <= cse_pkg::sat_sum(SW'(0) - SW'(rv_c[k]));
				vec_s7[cse_pkg::KIND_DUV][k] <= duv_s6[k];
			end
		end
	end

	// Output serializer: one wanted vector per cycle, lowest kind first.
	logic [5:0]       rem_q;
	logic [5:0]       pick;
	logic [5:0]       rest;
	logic [2:0]       kind;
	cse_pkg::result_t result_q;
	logic             strobe_q;

	always_comb begin
		pick = 6'd0;
		kind = cse_pkg::KIND_POS;
		for (int i = cse_pkg::NUM_KINDS - 1; i >= 0; i--) begin
			if (rem_q[i]) begin
				pick = 6'd1 << i;
				kind = 3'(i);
			end
		end
		rest = rem_q & ~pick;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q    <= 6'd0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (rem_q != 6'd0);
			if (valid_s6)
				rem_q <= mask_s6;
			else
				rem_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (rem_q != 6'd0) begin
			result_q.quantity_kind <= kind;
			result_q.vec_x         <= vec_s7[kind][0];
			result_q.vec_y         <= vec_s7[kind][1];
			result_q.vec_z         <= vec_s7[kind][2];
			result_q.last_of_run   <= (rest == 6'd0);
		end
	end

	assign result = result_q;
	assign strobe = strobe_q;

endmodule

/* sim/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint VEC_MAX = 64'sd140737488355327;
	localparam longint VEC_MIN = -VEC_MAX - 1;
	localparam int SETTLE = cse_pkg::CORDIC_STEPS + 16;
	localparam int CYCLE_LIMIT = 400000;

	typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_TYPED} row_kind_t;
	typedef struct {
		row_kind_t                          kind;
		logic [cse_pkg::CFG_IDX_W-1:0]      idx;
		logic [cse_pkg::CFG_DATA_W-1:0]     data;
		logic [15:0]                        u;
		logic signed [31:0]                 v;
		logic [5:0]                         mask;
		logic signed [cse_pkg::VW-1:0]      ex, ey, ez;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	cse_pkg::item_t item = '0;
	cse_pkg::result_t result;
	logic strobe;
	logic cfg_we = 1'b0;
	logic [cse_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [cse_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	cone_surface_evaluate_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.result(result), .strobe(strobe), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Shadow copy of the cone setup.
	longint cone_org [3];
	logic [53:0] axis_x, axis_y, axis_z;
	logic [31:0] cone_radius;
	logic [33:0] cone_trig;

	cse_pkg::result_t pending_vectors [$];
	logic typed_armed = 1'b0;
	cse_pkg::result_t typed_vector;
	int errors = 0;
	int requests = 0;
	int vectors_seen = 0;
	int cfg_writes = 0;
	int cycles = 0;

	function automatic longint clamp48(input longint x);
		if (x > VEC_MAX)
			return VEC_MAX;
		if (x < VEC_MIN)
			return VEC_MIN;
		return x;
	endfunction

	// Fixed-point product, rounded half away from zero, saturated.
	function automatic longint fx_mul(input longint a, input longint b);
		logic signed [127:0] p;
		logic [127:0] mag;
		p = 128'(signed'(a)) * 128'(signed'(b));
		mag = p[127] ? 128'(-p) : 128'(p);
		mag = (mag + (128'd1 << (cse_pkg::FRAC_BITS - 1))) >> cse_pkg::FRAC_BITS;
		if (p[127])
			return (mag >= 128'(VEC_MAX) + 1) ? VEC_MIN : -longint'(mag);
		return (mag > 128'(VEC_MAX)) ? VEC_MAX : longint'(mag);
	endfunction

	function automatic void unit_trig(input logic [15:0] ang, output longint co,
			output longint si);
		logic [31:0] a;
		logic [1:0] quad;
		longint z, x, y, dx, dy, c, s;
		a = 32'(ang) + 32'd8192;
		quad = a[15:14];
		z = (longint'(a & 32'd16383) - 8192) * 65536;
		x = 652032874;
		y = 0;
		for (int i = 0; i < cse_pkg::CORDIC_STEPS && i < cse_pkg::ATAN_N; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(cse_pkg::atan_turn(i));
			end else begin
				x += dx; y -= dy; z += longint'(cse_pkg::atan_turn(i));
			end
		end
		c = (x + (64'sd1 << (29 - cse_pkg::FRAC_BITS))) >>> (30 - cse_pkg::FRAC_BITS);
		s = (y + (64'sd1 << (29 - cse_pkg::FRAC_BITS))) >>> (30 - cse_pkg::FRAC_BITS);
		case (quad)
			2'd0: begin co = c; si = s; end
			2'd1: begin co = -s; si = c; end
			2'd2: begin co = -c; si = -s; end
			default: begin co = s; si = -c; end
		endcase
	endfunction

	function automatic void predict_cone_vectors(input cse_pkg::item_t req);
		longint c, s, v, rr, ch, sh, vscale, zscale, dvscale, dzscale;
		longint ax, ay, az, radial, tangent;
		longint vec [6][3];
		logic signed [17:0] comp;
		int final_kind;
		cse_pkg::result_t r;
		unit_trig(req.u_angle, c, s);
		v = longint'(req.v_param);
		rr = longint'(cone_radius);
		ch = longint'(cone_trig[16:0]);
		sh = longint'(cone_trig[33:17]);
		vscale = fx_mul(rr, clamp48((64'sd1 << cse_pkg::FRAC_BITS) - fx_mul(v, sh)));
		zscale = fx_mul(fx_mul(v, rr), ch);
		dvscale = clamp48(-fx_mul(rr, sh));
		dzscale = fx_mul(rr, ch);
		for (int k = 0; k < 3; k++) begin
			comp = axis_x[18*k +: 18]; ax = longint'(comp);
			comp = axis_y[18*k +: 18]; ay = longint'(comp);
			comp = axis_z[18*k +: 18]; az = longint'(comp);
			radial = clamp48(fx_mul(ax, c) + fx_mul(ay, s));
			tangent = clamp48(fx_mul(ay, c) - fx_mul(ax, s));
			vec[0][k] = clamp48(cone_org[k] + fx_mul(radial, vscale) + fx_mul(az, zscale));
			vec[1][k] = fx_mul(tangent, vscale);
			vec[2][k] = clamp48(fx_mul(radial, dvscale) + fx_mul(az, dzscale));
			vec[3][k] = clamp48(fx_mul(radial, ch) + fx_mul(az, sh));
			vec[4][k] = clamp48(-fx_mul(radial, vscale));
			vec[5][k] = fx_mul(tangent, dvscale);
		end
		final_kind = -1;
		for (int k = 0; k < cse_pkg::NUM_KINDS; k++)
			if (req.want_mask[k])
				final_kind = k;
		for (int k = 0; k < cse_pkg::NUM_KINDS; k++) begin
			if (req.want_mask[k]) begin
				r.quantity_kind = 3'(k);
				r.vec_x = vec[k][0][cse_pkg::VW-1:0];
				r.vec_y = vec[k][1][cse_pkg::VW-1:0];
				r.vec_z = vec[k][2][cse_pkg::VW-1:0];
				r.last_of_run = (k == final_kind);
				pending_vectors.push_back(r);
			end
		end
	endfunction

	always @(posedge clk) begin
		if (start && !busy) begin
			requests++;
			if (typed_armed) begin
				pending_vectors.push_back(typed_vector);
				typed_armed = 1'b0;
			end else begin
				predict_cone_vectors(item);
			end
		end
	end

	always @(posedge clk) begin
		if (strobe) begin
			vectors_seen++;
			if (pending_vectors.size() == 0) begin
				errors++;
				$display("%0t: unexpected vector kind=%0d x=%0d y=%0d z=%0d last=%0b",
					$time, result.quantity_kind, result.vec_x, result.vec_y,
					result.vec_z, result.last_of_run);
			end else begin
				if (result !== pending_vectors[0]) begin
					errors++;
					$display({"%0t: mismatch exp kind=%0d x=%0d y=%0d z=%0d last=%0b",
						" / act kind=%0d x=%0d y=%0d z=%0d last=%0b"},
						$time, pending_vectors[0].quantity_kind, pending_vectors[0].vec_x,
						pending_vectors[0].vec_y, pending_vectors[0].vec_z,
						pending_vectors[0].last_of_run, result.quantity_kind,
						result.vec_x, result.vec_y, result.vec_z, result.last_of_run);
				end
				void'(pending_vectors.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	// Lowers start and waits until the block has nothing left in flight.
	task automatic drain();
		start <= 1'b0;
		while (pending_vectors.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Leaves cfg_we high so that back-to-back writes need one assignment per edge.
	task automatic write_reg(input logic [cse_pkg::CFG_IDX_W-1:0] idx,
			input logic [cse_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			cse_pkg::REG_ORIGIN_X: cone_org[0] = longint'(signed'(data[31:0]));
			cse_pkg::REG_ORIGIN_Y: cone_org[1] = longint'(signed'(data[31:0]));
			cse_pkg::REG_ORIGIN_Z: cone_org[2] = longint'(signed'(data[31:0]));
			cse_pkg::REG_FRAME_X: axis_x = data[53:0];
			cse_pkg::REG_FRAME_Y: axis_y = data[53:0];
			cse_pkg::REG_FRAME_Z: axis_z = data[53:0];
			cse_pkg::REG_RADIUS: cone_radius = data[31:0];
			cse_pkg::REG_HALF_TRIG: cone_trig = data[33:0];
			default: ;
		endcase
		cfg_writes++;
		@(posedge clk);
	endtask

	task automatic send_request(input logic [15:0] u, input logic signed [31:0] v,
			input logic [5:0] mask, input int gap);
		start <= 1'b1;
		item <= '{u_angle: u, v_param: v, want_mask: mask};
		do @(posedge clk); while (busy);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [53:0] rand54();
		return {22'($urandom), $urandom};
	endfunction

	function automatic logic [53:0] pack_axis(input int x, input int y, input int z);
		return {18'(z), 18'(y), 18'(x)};
	endfunction

	function automatic int pick_gap(input int phase);
		if (phase % 3 == 2)
			return 0;
		if ($urandom_range(0, 11) == 0)
			return $urandom_range(20, 60);
		return $urandom_range(0, 2);
	endfunction

	task automatic load_phase(input int phase);
		drain();
		case (phase)
			0: begin
				write_reg(cse_pkg::REG_ORIGIN_X, 54'($urandom));
				write_reg(cse_pkg::REG_ORIGIN_Y, 54'($urandom));
				write_reg(cse_pkg::REG_ORIGIN_Z, 54'($urandom));
				write_reg(cse_pkg::REG_FRAME_X, cse_pkg::FRAME_X_RST);
				write_reg(cse_pkg::REG_FRAME_Y, cse_pkg::FRAME_Y_RST);
				write_reg(cse_pkg::REG_FRAME_Z, cse_pkg::FRAME_Z_RST);
				write_reg(cse_pkg::REG_RADIUS, 54'd131072);
				write_reg(cse_pkg::REG_HALF_TRIG, cse_pkg::TRIG_RST);
			end
			2: begin
				write_reg(cse_pkg::REG_ORIGIN_X, 54'h7FFFFFFF);
				write_reg(cse_pkg::REG_ORIGIN_Y, 54'h7FFFFFFF);
				write_reg(cse_pkg::REG_ORIGIN_Z, 54'h80000000);
				write_reg(cse_pkg::REG_FRAME_X, pack_axis(131071, -131072, 131071));
				write_reg(cse_pkg::REG_FRAME_Y, pack_axis(-131072, 131071, -131072));
				write_reg(cse_pkg::REG_FRAME_Z, {54{1'b1}});
				write_reg(cse_pkg::REG_RADIUS, 54'hFFFFFFFF);
				write_reg(cse_pkg::REG_HALF_TRIG, {34{1'b1}});
			end
			3: begin
				write_reg(cse_pkg::REG_ORIGIN_X, 54'h80000000);
				write_reg(cse_pkg::REG_ORIGIN_Y, 54'h80000000);
				write_reg(cse_pkg::REG_ORIGIN_Z, 54'h80000000);
				write_reg(cse_pkg::REG_FRAME_X, rand54());
				write_reg(cse_pkg::REG_FRAME_Y, rand54());
				write_reg(cse_pkg::REG_FRAME_Z, rand54());
				write_reg(cse_pkg::REG_RADIUS, 54'd0);
				write_reg(cse_pkg::REG_HALF_TRIG, 54'd0);
			end
			default: begin
				for (int r = 0; r < 8; r++)
					write_reg(cse_pkg::CFG_IDX_W'(r),
						(r >= 3 && r <= 5) ? rand54() : 54'({$urandom, $urandom}));
			end
		endcase
		cfg_we <= 1'b0;
	endtask

	initial begin
		row_t plan [$];
		int bit_pos;
		logic signed [31:0] v;

		cone_org[0] = 0; cone_org[1] = 0; cone_org[2] = 0;
		axis_x = cse_pkg::FRAME_X_RST;
		axis_y = cse_pkg::FRAME_Y_RST;
		axis_z = cse_pkg::FRAME_Z_RST;
		cone_radius = cse_pkg::RADIUS_RST;
		cone_trig = cse_pkg::TRIG_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		plan.push_back('{ROW_ITEM, 0, 0, 16'h0000, 0, 6'd0, 0, 0, 0});
		plan.push_back('{ROW_ITEM, 0, 0, 16'h0000, 0, 6'd63, 0, 0, 0});
		plan.push_back('{ROW_ITEM, 0, 0, 16'hFFFF, 32'sh7FFFFFFF, 6'd63, 0, 0, 0});
		plan.push_back('{ROW_ITEM, 0, 0, 16'h8000, 32'sh80000000, 6'd63, 0, 0, 0});
		plan.push_back('{ROW_ITEM, 0, 0, 16'h4000, -32'sd1, 6'd63, 0, 0, 0});
		plan.push_back('{ROW_ITEM, 0, 0, 16'h2000, 32'sd65536, 6'd42, 0, 0, 0});
		plan.push_back('{ROW_ITEM, 0, 0, 16'h1FFF, -32'sd65536, 6'd21, 0, 0, 0});
		plan.push_back('{ROW_ITEM, 0, 0, 16'hC000, 32'sd32768, 6'd8, 0, 0, 0});
		plan.push_back('{ROW_ITEM, 0, 0, 16'h6000, 32'sd12345, 6'd36, 0, 0, 0});
		// With a zero radius every scale vanishes: position is the origin.
		plan.push_back('{ROW_CFG, cse_pkg::REG_RADIUS, 0, 0, 0, 0, 0, 0, 0});
		plan.push_back('{ROW_CFG, cse_pkg::REG_ORIGIN_X, 54'h7FFFFFFF, 0, 0, 0, 0, 0, 0});
		plan.push_back('{ROW_CFG, cse_pkg::REG_ORIGIN_Y, 54'h80000000, 0, 0, 0, 0, 0, 0});
		plan.push_back('{ROW_CFG, cse_pkg::REG_ORIGIN_Z, 54'h12345, 0, 0, 0, 0, 0, 0});
		plan.push_back('{ROW_TYPED, 0, 0, 16'h1234, 32'sh7FFFFFFF, 6'd1,
			48'sh7FFFFFFF, -48'sh80000000, 48'sh12345});
		plan.push_back('{ROW_TYPED, 0, 0, 16'h9876, -32'sd5, 6'd16, 0, 0, 0});
		plan.push_back('{ROW_TYPED, 0, 0, 16'h4321, 32'sd7, 6'd32, 0, 0, 0});
		plan.push_back('{ROW_CFG, cse_pkg::REG_RADIUS, 54'hFFFFFFFF, 0, 0, 0, 0, 0, 0});
		plan.push_back('{ROW_ITEM, 0, 0, 16'h3000, 32'sh7FFFFFFF, 6'd63, 0, 0, 0});
		plan.push_back('{ROW_ITEM, 0, 0, 16'hA000, 32'sh80000000, 6'd63, 0, 0, 0});

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				if (i == 0 || plan[i-1].kind != ROW_CFG)
					drain();
				write_reg(plan[i].idx, plan[i].data);
				if (i + 1 >= plan.size() || plan[i+1].kind != ROW_CFG)
					cfg_we <= 1'b0;
			end else begin
				if (plan[i].kind == ROW_TYPED) begin
					bit_pos = 0;
					for (int k = 0; k < cse_pkg::NUM_KINDS; k++)
						if (plan[i].mask[k])
							bit_pos = k;
					typed_vector = '{quantity_kind: 3'(bit_pos), vec_x: plan[i].ex,
						vec_y: plan[i].ey, vec_z: plan[i].ez, last_of_run: 1'b1};
					typed_armed = 1'b1;
				end
				send_request(plan[i].u, plan[i].v, plan[i].mask, $urandom_range(0, 3));
				if (plan[i].kind == ROW_TYPED)
					drain();
			end
		end

		for (int phase = 0; phase < 6; phase++) begin
			load_phase(phase);
			for (int n = 0; n < 52; n++) begin
				if (phase == 1 && n == 26)
					drain();
				if ($urandom_range(0, 2) == 0)
					v = 32'($urandom);
				else
					v = 32'($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
				send_request(16'($urandom), v, 6'($urandom_range(0, 63)), pick_gap(phase));
			end
		end

		drain();
		$display("covered %0d requests, %0d vectors, %0d register writes over six setups",
			requests, vectors_seen, cfg_writes);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
